>>> sv/rtte_pkg.sv
// ----------------------------------------------------------------------------
// rtte_pkg
// Shared types and constants of the record tick timestamp expander.
// ----------------------------------------------------------------------------
package rtte_pkg;

   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_IDX_W-1:0] CSR_RECORD_LENGTH = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INTERVALS_PER_DAY = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_INTERVAL_START = 2'd2;

   localparam int LEN_W = 6;
   localparam int IPD_W = 17;
   localparam int TICK_W = 32;
   localparam int NUM_W = 49;
   localparam int DIV_W = 48;
   localparam int NANO_W = 30;
   localparam int EPOCH_W = 33;

   localparam logic [IPD_W-1:0] SECS_PER_DAY = 17'd86400;
   localparam logic [NANO_W-1:0] NANOS_PER_SEC = 30'd1000000000;
   localparam logic [LEN_W-1:0] MIN_RECORD_BYTES = 6'd5;
   localparam logic [LEN_W-1:0] TICK_BYTES = 6'd4;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       block_end;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       record_end;
      logic       block_end_out;
   } rsp_type;

   typedef struct packed {
      logic              bank;
      logic [LEN_W-1:0]  plen;
      logic [TICK_W-1:0] ticks;
      logic              bend;
   } job_type;

endpackage

>>> sv/rtte_ram.sv
// ----------------------------------------------------------------------------
// rtte_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module rtte_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 112
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

>>> sv/rtte_front.sv
// ----------------------------------------------------------------------------
// rtte_front
// Takes input bytes, stores payload into the current bank, collects the tick
// count and queues one job per finished record.
// ----------------------------------------------------------------------------
module rtte_front #(
   parameter int MAX_RECORD_BYTES = 56
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_push,
   input  rtte_pkg::req_type                        req_data,
   output logic                                     req_full,
   input  logic [rtte_pkg::LEN_W-1:0]               record_length,
   output logic                                     wr_en,
   output logic [$clog2(2*MAX_RECORD_BYTES)-1:0]    wr_addr,
   output logic [7:0]                               wr_data,
   output logic                                     job_valid,
   output rtte_pkg::job_type                        job_head,
   input  logic                                     job_pop
);
   import rtte_pkg::*;

   localparam int AW = $clog2(2*MAX_RECORD_BYTES);

   logic [LEN_W-1:0]  pos_ff, pos_in;
   logic [TICK_W-1:0] ticks_ff, ticks_in;
   logic              bank_ff, bank_in;
   job_type           q_ff [2];
   logic              rd_ptr_ff, wr_ptr_ff;
   logic [1:0]        cnt_ff;
   logic              accept, rec_done;
   logic [LEN_W-1:0]  len, plen;
   logic [LEN_W:0]    pos_next;
   logic [TICK_W-1:0] ticks_shift;

   always_comb begin
      if (record_length < MIN_RECORD_BYTES) begin
         len = MIN_RECORD_BYTES;
      end else if (record_length > LEN_W'(MAX_RECORD_BYTES)) begin
         len = LEN_W'(MAX_RECORD_BYTES);
      end else begin
         len = record_length;
      end
   end

   assign plen = len - TICK_BYTES;
   assign req_full = (cnt_ff == 2'd2);
   assign accept = req_push && !req_full;
   assign pos_next = {1'b0, pos_ff} + 7'd1;
   assign rec_done = (pos_next >= {1'b0, len});
   assign ticks_shift = (pos_ff < plen) ? ticks_ff : {req_data.in_byte, ticks_ff[TICK_W-1:8]};

   assign wr_en = accept && (pos_ff < plen);
   assign wr_addr = bank_ff ? AW'(MAX_RECORD_BYTES) + AW'(pos_ff) : AW'(pos_ff);
   assign wr_data = req_data.in_byte;

   always_comb begin
      pos_in = pos_ff;
      ticks_in = ticks_ff;
      bank_in = bank_ff;
      if (accept) begin
         if (rec_done) begin
            pos_in = '0;
            ticks_in = '0;
            bank_in = !bank_ff;
         end else begin
            pos_in = pos_next[LEN_W-1:0];
            ticks_in = ticks_shift;
         end
      end
   end

   assign job_valid = (cnt_ff != 2'd0);
   assign job_head = q_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (accept && rec_done) begin
         q_ff[wr_ptr_ff] <= '{bank: bank_ff, plen: plen, ticks: ticks_shift,
                              bend: req_data.block_end};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         ticks_ff <= '0;
         bank_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         wr_ptr_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         pos_ff <= pos_in;
         ticks_ff <= ticks_in;
         bank_ff <= bank_in;
         if (accept && rec_done) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (job_pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         cnt_ff <= cnt_ff + 2'((accept && rec_done) ? 1 : 0) - 2'(job_pop ? 1 : 0);
      end
   end
endmodule

>>> sv/rtte_divider.sv
// ----------------------------------------------------------------------------
// rtte_divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rtte_divider (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [rtte_pkg::DIV_W-1:0]  dividend,
   input  logic [rtte_pkg::IPD_W-1:0]  divisor,
   output logic                        done,
   output logic [rtte_pkg::DIV_W-1:0]  quotient,
   output logic [rtte_pkg::IPD_W-1:0]  remainder
);
   import rtte_pkg::*;

   localparam int CW = $clog2(DIV_W + 1);

   logic [DIV_W-1:0] dvd_ff;
   logic [IPD_W-1:0] rem_ff, dsr_ff;
   logic [CW-1:0]    cnt_ff;
   logic             busy_ff, done_ff;
   logic [IPD_W:0]   trial;
   logic             fits;

   assign trial = {rem_ff, dvd_ff[DIV_W-1]};
   assign fits = (trial >= {1'b0, dsr_ff});

   always_ff @(posedge clock) begin
      if (start) begin
         dvd_ff <= dividend;
         rem_ff <= '0;
         dsr_ff <= divisor;
      end else if (busy_ff) begin
         dvd_ff <= {dvd_ff[DIV_W-2:0], fits};
         rem_ff <= fits ? IPD_W'(trial - {1'b0, dsr_ff}) : trial[IPD_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + CW'(1);
            if (cnt_ff == CW'(DIV_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done = done_ff;
   assign quotient = dvd_ff;
   assign remainder = rem_ff;
endmodule

>>> sv/rtte_back.sv
// ----------------------------------------------------------------------------
// rtte_back
// Computes seconds and nanos of the queued record and streams the rewritten
// record through a small output queue.
// ----------------------------------------------------------------------------
module rtte_back #(
   parameter int MAX_RECORD_BYTES = 56
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     job_valid,
   input  rtte_pkg::job_type                        job_head,
   output logic                                     job_pop,
   input  logic [rtte_pkg::IPD_W-1:0]               intervals_per_day,
   input  logic [rtte_pkg::TICK_W-1:0]              interval_start_epoch,
   output logic                                     rd_en,
   output logic [$clog2(2*MAX_RECORD_BYTES)-1:0]    rd_addr,
   input  logic [7:0]                               rd_data,
   output logic                                     rsp_empty,
   input  logic                                     rsp_pop,
   output rtte_pkg::rsp_type                        rsp_data
);
   import rtte_pkg::*;

   localparam int AW = $clog2(2*MAX_RECORD_BYTES);
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_MUL2 = 3'd1;
   localparam logic [2:0] S_DIV1 = 3'd2;
   localparam logic [2:0] S_MUL3 = 3'd3;
   localparam logic [2:0] S_DIV2 = 3'd4;
   localparam logic [2:0] S_EMIT = 3'd5;
   localparam logic [1:0] K_EPOCH = 2'd0;
   localparam logic [1:0] K_PAYLOAD = 2'd1;
   localparam logic [1:0] K_NANOS = 2'd2;

   logic [2:0]         state_ff, state_in;
   logic [NUM_W-1:0]   num_ff;
   logic [NANO_W-1:0]  xl_ff, nanos_ff;
   logic [46:0]        xhp_ff;
   logic [IPD_W-1:0]   q_ff, iv;
   logic [EPOCH_W-1:0] epoch_ff;
   logic [LEN_W-1:0]   k_ff, plen_ff;
   logic               bank_ff, bend_ff;
   logic               div_start, div_done;
   logic [DIV_W-1:0]   div_dividend, div_quot;
   logic [IPD_W-1:0]   div_rem;
   logic               issue, last;
   logic [LEN_W-1:0]   pay_idx, nano_idx;
   logic               b_valid_ff, b_rend_ff, b_bend_ff;
   logic [1:0]         b_kind_ff;
   logic [2:0]         b_sel_ff;
   rsp_type            fifo_ff [4];
   logic [1:0]         fwr_ff, frd_ff;
   logic [2:0]         fcnt_ff;
   logic [7:0]         b_byte;
   logic [63:0]        epoch64;
   logic [31:0]        nanos32;
   logic               fpop;

   assign iv = (intervals_per_day == '0) ? IPD_W'(1) : intervals_per_day;

   rtte_divider u_div (
      .clock(clock), .reset(reset), .start(div_start), .dividend(div_dividend),
      .divisor(iv), .done(div_done), .quotient(div_quot), .remainder(div_rem)
   );

   assign div_start = (state_ff == S_MUL2) || (state_ff == S_MUL3);
   assign div_dividend = (state_ff == S_MUL2)
                         ? DIV_W'(num_ff[NUM_W-1:32])
                         : {1'b0, xhp_ff} + DIV_W'(xl_ff);

   // one result byte issued per cycle while the output queue has room
   assign issue = (state_ff == S_EMIT) && (({1'b0, fcnt_ff} + 4'(b_valid_ff)) <= 4'd2);
   assign last = (k_ff == plen_ff + 6'd11);
   assign job_pop = issue && last;
   assign pay_idx = k_ff - 6'd8;
   assign nano_idx = k_ff - 6'd8 - plen_ff;

   assign rd_en = issue && (k_ff >= 6'd8) && (pay_idx < plen_ff);
   assign rd_addr = bank_ff ? AW'(MAX_RECORD_BYTES) + AW'(pay_idx) : AW'(pay_idx);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: if (job_valid) state_in = S_MUL2;
         S_MUL2: state_in = S_DIV1;
         S_DIV1: if (div_done) state_in = S_MUL3;
         S_MUL3: state_in = S_DIV2;
         S_DIV2: if (div_done) state_in = S_EMIT;
         S_EMIT: if (job_pop) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE) begin
         num_ff <= NUM_W'(job_head.ticks) * NUM_W'(SECS_PER_DAY);
      end
      if (state_ff == S_MUL2) begin
         xl_ff <= NANO_W'((62'(num_ff[31:0]) * 62'(NANOS_PER_SEC)) >> 32);
      end
      if (state_ff == S_DIV1 && div_done) begin
         q_ff <= div_quot[IPD_W-1:0];
         xhp_ff <= 47'(div_rem) * 47'(NANOS_PER_SEC);
      end
      if (state_ff == S_MUL3) begin
         epoch_ff <= {1'b0, interval_start_epoch} + EPOCH_W'(q_ff);
      end
      if (state_ff == S_DIV2 && div_done) begin
         nanos_ff <= div_quot[NANO_W-1:0];
         plen_ff <= job_head.plen;
         bank_ff <= job_head.bank;
         bend_ff <= job_head.bend;
      end
      if (issue) begin
         priority if (k_ff < 6'd8) begin
            b_kind_ff <= K_EPOCH;
            b_sel_ff <= k_ff[2:0];
         end else if (pay_idx < plen_ff) begin
            b_kind_ff <= K_PAYLOAD;
            b_sel_ff <= '0;
         end else begin
            b_kind_ff <= K_NANOS;
            b_sel_ff <= {1'b0, nano_idx[1:0]};
         end
         b_rend_ff <= last;
         b_bend_ff <= last && bend_ff;
      end
   end

   assign epoch64 = 64'(epoch_ff);
   assign nanos32 = 32'(nanos_ff);

   always_comb begin
      unique case (b_kind_ff)
         K_EPOCH: b_byte = epoch64[8*b_sel_ff +: 8];
         K_PAYLOAD: b_byte = rd_data;
         default: b_byte = nanos32[8*b_sel_ff[1:0] +: 8];
      endcase
   end

   assign fpop = rsp_pop && (fcnt_ff != 3'd0);
   assign rsp_empty = (fcnt_ff == 3'd0);
   assign rsp_data = fifo_ff[frd_ff];

   always_ff @(posedge clock) begin
      if (b_valid_ff) begin
         fifo_ff[fwr_ff] <= '{out_byte: b_byte, record_end: b_rend_ff,
                             block_end_out: b_bend_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         k_ff <= '0;
         b_valid_ff <= 1'b0;
         fwr_ff <= '0;
         frd_ff <= '0;
         fcnt_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == S_DIV2) begin
            k_ff <= '0;
         end else if (issue) begin
            k_ff <= k_ff + 6'd1;
         end
         b_valid_ff <= issue;
         if (b_valid_ff) begin
            fwr_ff <= fwr_ff + 2'd1;
         end
         if (fpop) begin
            frd_ff <= frd_ff + 2'd1;
         end
         fcnt_ff <= fcnt_ff + 3'(b_valid_ff) - 3'(fpop);
      end
   end
endmodule

>>> sv/record_tick_timestamp_expander.sv
// ----------------------------------------------------------------------------
// record_tick_timestamp_expander
// Rewrites fixed-length records: tick count becomes 64-bit epoch seconds in
// front and 32-bit nanos at the end.
//
//   port group | direction | moves
//   req_*      | in        | one record byte per transfer
//   rsp_*      | out       | one rewritten byte per transfer
//   csr_*      | in        | register write, index and data
//
// Input bytes are taken one per cycle while req_full is low; a record is held
// in one of two payload banks so the next record streams in while the previous
// one is expanded. Per record the serial divider runs two 48-step divisions,
// then one byte is issued per cycle while the output queue has room (len + 8
// bytes). req_full rises when two finished records wait; reset is synchronous
// and clears control state only. A stalled rsp_pop backs up into the back end.
// ----------------------------------------------------------------------------
module record_tick_timestamp_expander #(
   parameter int MAX_RECORD_BYTES = 56
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_push,
   input  rtte_pkg::req_type                   req_data,
   output logic                                req_full,
   output logic                                rsp_empty,
   input  logic                                rsp_pop,
   output rtte_pkg::rsp_type                   rsp_data,
   input  logic                                csr_write_en,
   input  logic [rtte_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [rtte_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import rtte_pkg::*;

   localparam int AW = $clog2(2*MAX_RECORD_BYTES);

   logic [LEN_W-1:0]  record_length_ff;
   logic [IPD_W-1:0]  ipd_ff;
   logic [TICK_W-1:0] start_ff;
   logic              wr_en, rd_en, job_valid, job_pop;
   logic [AW-1:0]     wr_addr, rd_addr;
   logic [7:0]        wr_data, rd_data;
   job_type           job_head;

   always_ff @(posedge clock) begin
      if (reset) begin
         record_length_ff <= 6'd16;
         ipd_ff <= 17'd1440;
         start_ff <= '0;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_RECORD_LENGTH: record_length_ff <= csr_wdata[LEN_W-1:0];
            CSR_INTERVALS_PER_DAY: ipd_ff <= csr_wdata[IPD_W-1:0];
            CSR_INTERVAL_START: start_ff <= csr_wdata[TICK_W-1:0];
            default: ;
         endcase
      end
   end

   rtte_ram #(.WIDTH(8), .DEPTH(2*MAX_RECORD_BYTES)) u_ram (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_en(rd_en), .rd_addr(rd_addr), .rd_data(rd_data)
   );

   rtte_front #(.MAX_RECORD_BYTES(MAX_RECORD_BYTES)) u_front (
      .clock(clock), .reset(reset), .req_push(req_push), .req_data(req_data),
      .req_full(req_full), .record_length(record_length_ff), .wr_en(wr_en),
      .wr_addr(wr_addr), .wr_data(wr_data), .job_valid(job_valid),
      .job_head(job_head), .job_pop(job_pop)
   );

   rtte_back #(.MAX_RECORD_BYTES(MAX_RECORD_BYTES)) u_back (
      .clock(clock), .reset(reset), .job_valid(job_valid), .job_head(job_head),
      .job_pop(job_pop), .intervals_per_day(ipd_ff),
      .interval_start_epoch(start_ff), .rd_en(rd_en), .rd_addr(rd_addr),
      .rd_data(rd_data), .rsp_empty(rsp_empty), .rsp_pop(rsp_pop),
      .rsp_data(rsp_data)
   );
endmodule
